@@ hdl/faa_pkg.sv @@
// shared types and constants for the frame activity accumulator
`timescale 1ns / 1ps

package faa_pkg;

   localparam int KEY_SLOTS = 24;
   localparam int KEY_W     = 16;
   localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int FILL_W    = $clog2(KEY_SLOTS + 1);

   localparam logic [11:0]       MIN_FRAME_BYTES = 12'd30;
   localparam logic signed [7:0] RESET_THRESHOLD = -8'sd65;
   localparam logic [3:0]        RESET_CHANNELS  = 4'd13;
   localparam logic [3:0]        FIRST_CHANNEL   = 4'd1;

   localparam logic       OP_FRAME = 1'b0;
   localparam logic       OP_DWELL = 1'b1;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_CHANNELS  = 1'b1;

   typedef struct packed {
      logic             go;
      logic             clear;
      logic [KEY_W-1:0] key;
   } kt_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic [FILL_W-1:0] fill;
   } kt_stat_type;

endpackage

@@ hdl/faa_key_table.sv @@
// transmitter key store with a single comparator walked over the filled slots
`timescale 1ns / 1ps

module faa_key_table
   import faa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  kt_ctrl_type ctrl,
   output kt_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  rd_data_ff;
   logic [KEY_W-1:0]  mem [KEY_SLOTS];

   logic issue;
   logic found;
   logic wr_en;

   assign issue = (state_ff == ST_SCAN) && (scan_ff < fill_ff);
   assign found = cmp_vld_ff && (rd_data_ff == key_ff);
   assign wr_en = (state_ff == ST_SCAN) && !found && !issue && !cmp_vld_ff &&
                  (fill_ff < FILL_W'(KEY_SLOTS));

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;
      key_in     = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.clear) begin
               fill_in = '0;
            end
            if (ctrl.go) begin
               key_in   = ctrl.key;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_IDLE;
            end else if (issue) begin
               cmp_vld_in = 1'b1;
               scan_in    = scan_ff + FILL_W'(1);
            end else if (!cmp_vld_ff) begin
               if (wr_en) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[IDX_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.fill = fill_ff;

endmodule

@@ hdl/frame_activity_accumulator.sv @@
// top level: dwell counters, channel stepping, config registers and key table
// an end-of-dwell item raises its result strobe in the cycle after it is accepted
// a counted frame holds busy while one comparator walks the filled key slots
// through a registered memory read; other items do not raise busy
// synchronous reset clears the counters and key fill, sets channel 1,
// threshold -65 dBm and channel count 13; the receiver cannot stall results
`timescale 1ns / 1ps

module frame_activity_accumulator
   import faa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [1:0]        req_frame_kind,
   input  logic [11:0]       req_frame_length,
   input  logic signed [7:0] req_signal_strength,
   input  logic [15:0]       req_transmitter_tail,
   output logic              rsp_valid,
   output logic [3:0]        rsp_dwell_channel,
   output logic [31:0]       rsp_frame_total,
   output logic [31:0]       rsp_byte_total,
   output logic [15:0]       rsp_strong_total,
   output logic [4:0]        rsp_distinct_total,
   output logic [3:0]        rsp_following_channel,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);

   logic signed [7:0] threshold_ff;
   logic [3:0]        channels_ff;
   logic [31:0]       frames_ff, frames_in;
   logic [31:0]       bytes_ff, bytes_in;
   logic [15:0]       strong_ff, strong_in;
   logic [3:0]        channel_ff, channel_in;
   logic              rsp_valid_ff;
   logic [3:0]        rsp_chan_ff;
   logic [31:0]       rsp_frames_ff;
   logic [31:0]       rsp_bytes_ff;
   logic [15:0]       rsp_strong_ff;
   logic [4:0]        rsp_distinct_ff;
   logic [3:0]        rsp_next_ff;

   kt_ctrl_type kt_ctrl;
   kt_stat_type kt_stat;

   logic       accept;
   logic       counted;
   logic       dwell_end;
   logic [4:0] next_wide;
   logic [3:0] next_chan;

   assign busy      = kt_stat.busy;
   assign accept    = start && !busy;
   assign counted   = accept && (req_operation == OP_FRAME) &&
                      (req_frame_kind != KIND_OTHER) &&
                      (req_frame_length >= MIN_FRAME_BYTES);
   assign dwell_end = accept && (req_operation == OP_DWELL);
   assign next_wide = {1'b0, channel_ff} + 5'd1;
   assign next_chan = (next_wide > {1'b0, channels_ff}) ? FIRST_CHANNEL : next_wide[3:0];

   assign kt_ctrl.go    = counted;
   assign kt_ctrl.clear = dwell_end;
   assign kt_ctrl.key   = req_transmitter_tail;

   faa_key_table u_key_table (
      .clock (clock),
      .reset (reset),
      .ctrl  (kt_ctrl),
      .stat  (kt_stat)
   );

   always_comb begin
      frames_in  = frames_ff;
      bytes_in   = bytes_ff;
      strong_in  = strong_ff;
      channel_in = channel_ff;
      if (counted) begin
         frames_in = frames_ff + 32'd1;
         bytes_in  = bytes_ff + {20'd0, req_frame_length};
         if (req_signal_strength >= threshold_ff) begin
            strong_in = strong_ff + 16'd1;
         end
      end else if (dwell_end) begin
         frames_in  = '0;
         bytes_in   = '0;
         strong_in  = '0;
         channel_in = next_chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RESET_THRESHOLD;
         channels_ff  <= RESET_CHANNELS;
         frames_ff    <= '0;
         bytes_ff     <= '0;
         strong_ff    <= '0;
         channel_ff   <= FIRST_CHANNEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_wdata;
               CSR_CHANNELS:  channels_ff  <= csr_wdata[3:0];
               default:       threshold_ff <= threshold_ff;
            endcase
         end
         frames_ff    <= frames_in;
         bytes_ff     <= bytes_in;
         strong_ff    <= strong_in;
         channel_ff   <= channel_in;
         rsp_valid_ff <= dwell_end;
      end
      if (dwell_end) begin
         rsp_chan_ff     <= channel_ff;
         rsp_frames_ff   <= frames_ff;
         rsp_bytes_ff    <= bytes_ff;
         rsp_strong_ff   <= strong_ff;
         rsp_distinct_ff <= 5'(kt_stat.fill);
         rsp_next_ff     <= next_chan;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dwell_channel     = rsp_chan_ff;
   assign rsp_frame_total       = rsp_frames_ff;
   assign rsp_byte_total        = rsp_bytes_ff;
   assign rsp_strong_total      = rsp_strong_ff;
   assign rsp_distinct_total    = rsp_distinct_ff;
   assign rsp_following_channel = rsp_next_ff;

endmodule

@@ dv/frame_activity_accumulator_tb.sv @@
// self-checking testbench for the frame activity accumulator: dwell tracker plus drivers
`timescale 1ns / 1ps

module frame_activity_accumulator_tb;
   import faa_pkg::*;

   localparam logic [1:0] KIND_MGMT = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_CTRL = 2'd2;

   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASES       = 6;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_TICKS = KEY_SLOTS + 16;

   typedef struct packed {
      logic [3:0]  dwell_channel;
      logic [31:0] frame_total;
      logic [31:0] byte_total;
      logic [15:0] strong_total;
      logic [4:0]  distinct_total;
      logic [3:0]  following_channel;
   } dwell_report_type;

   class dwell_tracker;
      logic signed [7:0] threshold;
      logic [3:0]        chan_limit;
      logic [31:0]       frames_acc;
      logic [31:0]       bytes_acc;
      logic [15:0]       strong_acc;
      logic [15:0]       keys_seen[$];
      logic [3:0]        channel;
      dwell_report_type  reports_due[$];
      int                errors;
      int                reports_checked;
      int                frames_counted;
      int                keys_dropped;
      int                reg_writes;

      function new();
         threshold       = RESET_THRESHOLD;
         chan_limit      = RESET_CHANNELS;
         channel         = FIRST_CHANNEL;
         errors          = 0;
         reports_checked = 0;
         frames_counted  = 0;
         keys_dropped    = 0;
         reg_writes      = 0;
         clear_dwell();
      endfunction

      function void clear_dwell();
         frames_acc = '0;
         bytes_acc  = '0;
         strong_acc = '0;
         keys_seen.delete();
      endfunction

      function int backlog();
         return reports_due.size();
      endfunction

      function void write_reg(logic idx, logic [7:0] data);
         reg_writes++;
         if (idx == CSR_THRESHOLD) begin
            threshold = data;
         end else begin
            chan_limit = data[3:0];
         end
      endfunction

      function void note_item(logic op, logic [1:0] kind, logic [11:0] len,
                              logic signed [7:0] sig, logic [15:0] tail);
         bit               known;
         logic [4:0]       nxt;
         dwell_report_type rpt;
         known = 1'b0;
         if (op == OP_FRAME) begin
            if (kind == KIND_OTHER || len < MIN_FRAME_BYTES) return;
            frames_counted++;
            frames_acc = frames_acc + 32'd1;
            bytes_acc  = bytes_acc + {20'd0, len};
            if (sig >= threshold) strong_acc = strong_acc + 16'd1;
            foreach (keys_seen[i]) begin
               if (keys_seen[i] == tail) known = 1'b1;
            end
            if (!known) begin
               if (keys_seen.size() < KEY_SLOTS) begin
                  keys_seen.push_back(tail);
               end else begin
                  keys_dropped++;
               end
            end
         end else begin
            nxt = {1'b0, channel} + 5'd1;
            if (nxt > {1'b0, chan_limit}) nxt = 5'd1;
            rpt.dwell_channel     = channel;
            rpt.frame_total       = frames_acc;
            rpt.byte_total        = bytes_acc;
            rpt.strong_total      = strong_acc;
            rpt.distinct_total    = 5'(keys_seen.size());
            rpt.following_channel = nxt[3:0];
            reports_due.push_back(rpt);
            clear_dwell();
            channel = nxt[3:0];
         end
      endfunction

      function void check_report(dwell_report_type got);
         dwell_report_type want;
         if (reports_due.size() == 0) begin
            $error("dwell report with none expected, dwell_channel %0d", got.dwell_channel);
            errors++;
            return;
         end
         want = reports_due.pop_front();
         reports_checked++;
         if (got.dwell_channel !== want.dwell_channel) begin
            $error("dwell_channel: expected %0d, got %0d",
                   want.dwell_channel, got.dwell_channel);
            errors++;
         end
         if (got.frame_total !== want.frame_total) begin
            $error("frame_total: expected %0d, got %0d", want.frame_total, got.frame_total);
            errors++;
         end
         if (got.byte_total !== want.byte_total) begin
            $error("byte_total: expected %0d, got %0d", want.byte_total, got.byte_total);
            errors++;
         end
         if (got.strong_total !== want.strong_total) begin
            $error("strong_total: expected %0d, got %0d", want.strong_total, got.strong_total);
            errors++;
         end
         if (got.distinct_total !== want.distinct_total) begin
            $error("distinct_total: expected %0d, got %0d",
                   want.distinct_total, got.distinct_total);
            errors++;
         end
         if (got.following_channel !== want.following_channel) begin
            $error("following_channel: expected %0d, got %0d",
                   want.following_channel, got.following_channel);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_operation = OP_FRAME;
   logic [1:0]        req_frame_kind = KIND_MGMT;
   logic [11:0]       req_frame_length = '0;
   logic signed [7:0] req_signal_strength = '0;
   logic [15:0]       req_transmitter_tail = '0;
   logic              rsp_valid;
   logic [3:0]        rsp_dwell_channel;
   logic [31:0]       rsp_frame_total;
   logic [31:0]       rsp_byte_total;
   logic [15:0]       rsp_strong_total;
   logic [4:0]        rsp_distinct_total;
   logic [3:0]        rsp_following_channel;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_THRESHOLD;
   logic [7:0]        csr_wdata = '0;

   dwell_tracker     sb;
   dwell_report_type seen_report;
   int               quiet_cycles = 0;
   int               items_sent = 0;

   frame_activity_accumulator uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_frame_kind        (req_frame_kind),
      .req_frame_length      (req_frame_length),
      .req_signal_strength   (req_signal_strength),
      .req_transmitter_tail  (req_transmitter_tail),
      .rsp_valid             (rsp_valid),
      .rsp_dwell_channel     (rsp_dwell_channel),
      .rsp_frame_total       (rsp_frame_total),
      .rsp_byte_total        (rsp_byte_total),
      .rsp_strong_total      (rsp_strong_total),
      .rsp_distinct_total    (rsp_distinct_total),
      .rsp_following_channel (rsp_following_channel),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // monitor: register writes, reports, accepted items and the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid) begin
            seen_report.dwell_channel     = rsp_dwell_channel;
            seen_report.frame_total       = rsp_frame_total;
            seen_report.byte_total        = rsp_byte_total;
            seen_report.strong_total      = rsp_strong_total;
            seen_report.distinct_total    = rsp_distinct_total;
            seen_report.following_channel = rsp_following_channel;
            sb.check_report(seen_report);
         end
         if (start && !busy) begin
            items_sent++;
            sb.note_item(req_operation, req_frame_kind, req_frame_length,
                         req_signal_strength, req_transmitter_tail);
         end
         if ((start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic [1:0] kind, input logic [11:0] len,
                            input logic signed [7:0] sig, input logic [15:0] tail,
                            input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation        <= op;
      req_frame_kind       <= kind;
      req_frame_length     <= len;
      req_signal_strength  <= sig;
      req_transmitter_tail <= tail;
      start                <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every pending dwell report has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (sb.backlog() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic reconfigure(input logic [7:0] thr, input logic [3:0] chans);
      settle();
      repeat (SETTLE_TICKS) @(posedge clock);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_CHANNELS, {4'($urandom_range(0, 15)), chans});
   endtask

   task automatic run_random_dwell(inout int counted);
      int          mode;
      int          nframes;
      int          r;
      bit          calm;
      logic [15:0] pool [6];
      logic [1:0]  kind;
      logic [11:0] len;
      logic [15:0] tail;
      mode    = $urandom_range(0, 9);
      calm    = ($urandom_range(0, 3) == 0);
      nframes = (mode >= 8) ? $urandom_range(26, 34) : $urandom_range(0, 12);
      foreach (pool[i]) pool[i] = 16'($urandom_range(0, 65535));
      for (int f = 0; f < nframes; f++) begin
         r = $urandom_range(0, 9);
         kind = (r == 0) ? KIND_OTHER : 2'($urandom_range(0, 2));
         r = $urandom_range(0, 9);
         if (r == 0) len = 12'($urandom_range(0, 29));
         else if (r == 1) len = 12'($urandom_range(28, 32));
         else len = 12'($urandom_range(30, 4095));
         tail = (mode < 5) ? pool[$urandom_range(0, 5)] : 16'($urandom_range(0, 65535));
         send_item(OP_FRAME, kind, len, 8'($urandom_range(0, 255)), tail, calm);
         counted++;
      end
      // fields other than the operation are don't-care on end of dwell
      send_item(OP_DWELL, 2'($urandom), 12'($urandom), 8'($urandom), 16'($urandom), calm);
      counted++;
      if ($urandom_range(0, 7) == 0) settle();
   endtask

   initial begin
      int          counted;
      logic [7:0]  thr;
      logic [3:0]  chans;
      sb = new();
      counted = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: length and strength edges, ignored frames, repeated keys
      send_item(OP_FRAME, KIND_MGMT, MIN_FRAME_BYTES, RESET_THRESHOLD, 16'h0000, 1'b0);
      send_item(OP_FRAME, KIND_DATA, 12'hFFF, 8'sd127, 16'hFFFF, 1'b0);
      send_item(OP_FRAME, KIND_CTRL, 12'd29, 8'sd0, 16'h1234, 1'b0);
      send_item(OP_FRAME, KIND_OTHER, 12'd100, 8'sd0, 16'h4321, 1'b0);
      send_item(OP_FRAME, KIND_CTRL, 12'd31, -8'sd66, 16'h0000, 1'b0);
      send_item(OP_FRAME, KIND_MGMT, 12'd0, -8'sd128, 16'h0000, 1'b0);
      send_item(OP_FRAME, KIND_DATA, 12'd1000, -8'sd128, 16'hA5A5, 1'b1);
      send_item(OP_DWELL, KIND_OTHER, 12'hFFF, 8'sd127, 16'hFFFF, 1'b1);
      send_item(OP_DWELL, KIND_MGMT, 12'd0, -8'sd128, 16'h0000, 1'b0);
      settle();

      // channel wrap with a single channel, lowest threshold
      reconfigure(8'h80, 4'd1);
      send_item(OP_FRAME, KIND_MGMT, 12'd30, -8'sd128, 16'h5A5A, 1'b0);
      send_item(OP_DWELL, KIND_DATA, 12'd0, 8'sd0, 16'h0000, 1'b0);
      send_item(OP_DWELL, KIND_CTRL, 12'd0, 8'sd0, 16'h0000, 1'b1);

      // zero threshold and channel count zero
      reconfigure(8'h00, 4'd0);
      send_item(OP_FRAME, KIND_CTRL, 12'd64, 8'sd0, 16'h00FF, 1'b0);
      send_item(OP_FRAME, KIND_DATA, 12'd64, -8'sd1, 16'hFF00, 1'b0);
      send_item(OP_DWELL, KIND_MGMT, 12'd0, 8'sd0, 16'h0000, 1'b0);

      // highest threshold
      reconfigure(8'h7F, 4'd15);
      send_item(OP_FRAME, KIND_MGMT, 12'd4000, 8'sd127, 16'hBEEF, 1'b0);
      send_item(OP_DWELL, KIND_DATA, 12'd0, 8'sd0, 16'h0000, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin thr = 8'h80; chans = 4'd14; end
            1: begin thr = 8'h00; chans = 4'd1; end
            2: begin thr = RESET_THRESHOLD; chans = 4'd15; end
            3: begin thr = 8'h7F; chans = 4'd0; end
            4: begin thr = 8'($urandom_range(0, 255)); chans = 4'($urandom_range(0, 15)); end
            default: begin thr = 8'(-$urandom_range(0, 128)); chans = RESET_CHANNELS; end
         endcase
         reconfigure(thr, chans);
         while (counted < (phase + 1) * RANDOM_ITEMS / PHASES) run_random_dwell(counted);
      end

      settle();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (sb.backlog() != 0) begin
         $error("%0d dwell reports never arrived", sb.backlog());
         sb.errors++;
      end
      $display("run covered %0d items, %0d counted frames, %0d dwell reports checked",
               items_sent, sb.frames_counted, sb.reports_checked);
      $display("  %0d keys dropped on a full table, %0d register writes",
               sb.keys_dropped, sb.reg_writes);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
